>>> hdl/gcpw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph coverage pixel writer package
// Shared field widths, command codes, register indexes and control types.
// ----------------------------------------------------------------------------
package gcpw_pkg;

    localparam int CMD_W   = 2;
    localparam int COORD_W = 13;
    localparam int GLYPH_W = 8;
    localparam int CHAN_W  = 8;
    localparam int POS_W   = 12;
    localparam int COLOR_W = 32;
    localparam int NUM_CH  = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CMD_W-1:0] CMD_GLYPH  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FLUSH  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DIRECT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_TEX_W   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TEX_H   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AA      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PREMULT = 3'd4;

    localparam logic [COORD_W-1:0] RESET_DIM   = 13'd256;
    localparam logic [COLOR_W-1:0] RESET_COLOR = 32'hFFFF_FFFF;
    localparam logic [CHAN_W-1:0]  CHAN_SAT    = 8'hFF;

    typedef struct packed {
        logic load_in;
        logic mul;
        logic div_load;
        logic div_step;
        logic finish;
    } gcpw_ctrl_t;

endpackage

>>> hdl/glyph_coverage_pixel_writer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph coverage pixel writer
// Clips, flips and scales glyph pixels into texture writes and tracks the
// dirty rectangle.
//
// The slave stream takes one word per glyph pixel, flush or direct write,
// with the command in s_tuser. The master stream returns exactly one word
// per accepted word: the pixel write flag in m_tuser, the write position and
// color, and the dirty rectangle grown by the write, before a flush clears it.
// Configuration is written through cfg_we, cfg_index and cfg_data; the user
// must write it only while the block is idle; the block does not enforce it.
// Each word passes through acceptance, one multiply step, one divider load,
// eight restoring divide steps shared by four channel lanes, and the
// hand-off to the output register, from which it shows on m_tdata. A new
// word is accepted while the previous result still waits in the output
// register; if the receiver stalls longer, the finished result waits
// inside and s_tready stays low.
// Reset restores the default registers and a full dirty rectangle.
// ----------------------------------------------------------------------------
module glyph_coverage_pixel_writer
    import gcpw_pkg::*;
#(
    parameter int MAX_DIM = 4096
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // origin_x, origin_y, glyph_col, glyph_row, coverage, coverage_full
    input  logic [63:0]           s_tdata,
    // cmd
    input  logic [CMD_W-1:0]      s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // write_x, write_y, write_color, rect_dirty, rect_min_x, rect_max_x,
    // rect_min_y, rect_max_y
    output logic [111:0]          m_tdata,
    // write_enable
    output logic                  m_tuser,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    gcpw_ctrl_t         ctrl;
    logic [POS_W-1:0]   write_x;
    logic [POS_W-1:0]   write_y;
    logic [COLOR_W-1:0] write_color;
    logic               rect_dirty;
    logic [COORD_W-1:0] rect_min_x;
    logic [COORD_W-1:0] rect_max_x;
    logic [COORD_W-1:0] rect_min_y;
    logic [COORD_W-1:0] rect_max_y;

    gcpw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .ctrl     (ctrl)
    );

    gcpw_dp #(
        .MAX_DIM (MAX_DIM)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cmd           (s_tuser),
        .origin_x      (s_tdata[12:0]),
        .origin_y      (s_tdata[25:13]),
        .glyph_col     (s_tdata[33:26]),
        .glyph_row     (s_tdata[41:34]),
        .coverage      (s_tdata[49:42]),
        .coverage_full (s_tdata[57:50]),
        .ctrl          (ctrl),
        .write_enable  (m_tuser),
        .write_x       (write_x),
        .write_y       (write_y),
        .write_color   (write_color),
        .rect_dirty    (rect_dirty),
        .rect_min_x    (rect_min_x),
        .rect_max_x    (rect_max_x),
        .rect_min_y    (rect_min_y),
        .rect_max_y    (rect_max_y)
    );

    assign m_tdata = {3'b000, rect_max_y, rect_min_y, rect_max_x, rect_min_x,
                      rect_dirty, write_color, write_y, write_x};

endmodule

>>> hdl/gcpw_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Channel scaler
// Registers value * coverage, then finds floor(product / full) one quotient
// bit per step with a restoring divider, saturated at 255.
// ----------------------------------------------------------------------------
module gcpw_div
    import gcpw_pkg::*;
(
    input  logic              clk,
    input  logic              mul,
    input  logic              load,
    input  logic              step,
    input  logic [CHAN_W-1:0] value,
    input  logic [CHAN_W-1:0] cov,
    input  logic [CHAN_W-1:0] full,
    output logic [CHAN_W-1:0] result
);

    logic [2*CHAN_W-1:0] prod_reg, prod_next;
    logic [CHAN_W-1:0]   rem_reg, rem_next;
    logic [CHAN_W-1:0]   quot_reg, quot_next;
    logic                sat_reg, sat_next;
    logic                zero_reg, zero_next;
    logic [CHAN_W:0]     trial;
    logic                fits;

    assign trial = {rem_reg, quot_reg[CHAN_W-1]};
    assign fits  = trial >= {1'b0, full};

    always_comb
    begin
        prod_next = prod_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        sat_next  = sat_reg;
        zero_next = zero_reg;
        if (mul)
        begin
            prod_next = value * cov;
        end
        if (load)
        begin
            rem_next  = prod_reg[2*CHAN_W-1:CHAN_W];
            quot_next = prod_reg[CHAN_W-1:0];
            sat_next  = prod_reg[2*CHAN_W-1:CHAN_W] >= full;
            zero_next = prod_reg == '0;
        end
        else if (step)
        begin
            rem_next  = fits ? CHAN_W'(trial - {1'b0, full}) : trial[CHAN_W-1:0];
            quot_next = {quot_reg[CHAN_W-2:0], fits};
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        sat_reg  <= sat_next;
        zero_reg <= zero_next;
    end

    assign result = zero_reg ? '0 : (sat_reg ? CHAN_SAT : quot_reg);

endmodule

>>> hdl/gcpw_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph coverage pixel writer datapath
// Configuration registers, clipping and flip, channel scalers, output word
// and the dirty rectangle.
// ----------------------------------------------------------------------------
module gcpw_dp
    import gcpw_pkg::*;
#(
    parameter int MAX_DIM = 4096
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [CMD_W-1:0]      cmd,
    input  logic [COORD_W-1:0]    origin_x,
    input  logic [COORD_W-1:0]    origin_y,
    input  logic [GLYPH_W-1:0]    glyph_col,
    input  logic [GLYPH_W-1:0]    glyph_row,
    input  logic [CHAN_W-1:0]     coverage,
    input  logic [CHAN_W-1:0]     coverage_full,
    input  gcpw_ctrl_t            ctrl,
    output logic                  write_enable,
    output logic [POS_W-1:0]      write_x,
    output logic [POS_W-1:0]      write_y,
    output logic [COLOR_W-1:0]    write_color,
    output logic                  rect_dirty,
    output logic [COORD_W-1:0]    rect_min_x,
    output logic [COORD_W-1:0]    rect_max_x,
    output logic [COORD_W-1:0]    rect_min_y,
    output logic [COORD_W-1:0]    rect_max_y
);

    localparam int DimW = 15;
    localparam logic [DimW-1:0] DimLimit = DimW'(MAX_DIM);

    logic [COORD_W-1:0] tex_w_reg, tex_w_next;
    logic [COORD_W-1:0] tex_h_reg, tex_h_next;
    logic [COLOR_W-1:0] color_reg, color_next;
    logic               aa_reg, aa_next;
    logic               pm_reg, pm_next;

    logic               dirty_reg, dirty_next;
    logic [COORD_W-1:0] left_reg, left_next;
    logic [COORD_W-1:0] right_reg, right_next;
    logic [COORD_W-1:0] top_reg, top_next;
    logic [COORD_W-1:0] bottom_reg, bottom_next;

    logic [CMD_W-1:0]   cmd_reg, cmd_next;
    logic [COORD_W-1:0] ox_reg, ox_next;
    logic [COORD_W-1:0] oy_reg, oy_next;
    logic [GLYPH_W-1:0] col_reg, col_next;
    logic [GLYPH_W-1:0] row_reg, row_next;
    logic [CHAN_W-1:0]  cov_reg, cov_next;
    logic [CHAN_W-1:0]  full_reg, full_next;

    logic               we_reg, we_next;
    logic [COORD_W-1:0] x_reg, x_next;
    logic [COORD_W-1:0] y_reg, y_next;
    logic               scale_reg, scale_next;
    logic               flush_reg, flush_next;

    logic               out_we_reg, out_we_next;
    logic [POS_W-1:0]   out_x_reg, out_x_next;
    logic [POS_W-1:0]   out_y_reg, out_y_next;
    logic [COLOR_W-1:0] out_color_reg, out_color_next;
    logic               out_dirty_reg, out_dirty_next;
    logic [COORD_W-1:0] out_left_reg, out_left_next;
    logic [COORD_W-1:0] out_right_reg, out_right_next;
    logic [COORD_W-1:0] out_top_reg, out_top_next;
    logic [COORD_W-1:0] out_bottom_reg, out_bottom_next;

    logic [COORD_W-1:0] eff_w;
    logic [COORD_W-1:0] eff_h;
    logic [COORD_W:0]   px;
    logic [COORD_W:0]   pr;
    logic               px_in;
    logic               pr_in;
    logic               ox_in;
    logic               oy_in;
    logic               mono_bit;
    logic               glyph_hit;
    logic [COORD_W-1:0] flip_y;
    logic [COORD_W-1:0] x_end;
    logic [COORD_W-1:0] y_end;
    logic               grow_dirty;
    logic [COORD_W-1:0] grow_left;
    logic [COORD_W-1:0] grow_right;
    logic [COORD_W-1:0] grow_top;
    logic [COORD_W-1:0] grow_bottom;
    logic [COLOR_W-1:0] color_sel;
    logic [CHAN_W-1:0]  scaled [NUM_CH];

    // Lane i scales byte i of the draw color; lane 3 is alpha.
    for (genvar i = 0; i < NUM_CH; i++)
    begin : g_lane
        gcpw_div u_div (
            .clk    (clk),
            .mul    (ctrl.mul),
            .load   (ctrl.div_load),
            .step   (ctrl.div_step),
            .value  (color_reg[i*CHAN_W +: CHAN_W]),
            .cov    (cov_reg),
            .full   (full_reg),
            .result (scaled[i])
        );
    end

    assign eff_w = (DimW'(tex_w_reg) > DimLimit) ? DimLimit[COORD_W-1:0] : tex_w_reg;
    assign eff_h = (DimW'(tex_h_reg) > DimLimit) ? DimLimit[COORD_W-1:0] : tex_h_reg;

    assign px = {ox_reg[COORD_W-1], ox_reg} + (COORD_W+1)'(col_reg);
    assign pr = {oy_reg[COORD_W-1], oy_reg} + (COORD_W+1)'(row_reg);
    assign px_in = !px[COORD_W] && (px[COORD_W-1:0] < eff_w);
    assign pr_in = !pr[COORD_W] && (pr[COORD_W-1:0] < eff_h);
    assign ox_in = !ox_reg[COORD_W-1] && (ox_reg < eff_w);
    assign oy_in = !oy_reg[COORD_W-1] && (oy_reg < eff_h);
    assign mono_bit  = cov_reg[3'd7 - col_reg[2:0]];
    assign glyph_hit = aa_reg ? (cov_reg != '0) : mono_bit;
    assign flip_y    = COORD_W'(eff_h - 13'd1 - pr[COORD_W-1:0]);

    always_comb
    begin
        we_next    = we_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        scale_next = scale_reg;
        flush_next = flush_reg;
        if (ctrl.mul)
        begin
            scale_next = aa_reg && (cmd_reg == CMD_GLYPH);
            flush_next = cmd_reg == CMD_FLUSH;
            case (cmd_reg)
                CMD_GLYPH:
                begin
                    we_next = px_in && pr_in && glyph_hit;
                    x_next  = px[COORD_W-1:0];
                    y_next  = flip_y;
                end
                CMD_DIRECT:
                begin
                    we_next = ox_in && oy_in;
                    x_next  = ox_reg;
                    y_next  = oy_reg;
                end
                default:
                begin
                    we_next = 1'b0;
                    x_next  = '0;
                    y_next  = '0;
                end
            endcase
        end
    end

    assign x_end = COORD_W'(x_reg + 13'd1);
    assign y_end = COORD_W'(y_reg + 13'd1);
    assign grow_dirty  = dirty_reg || we_reg;
    assign grow_left   = (we_reg && (x_reg < left_reg)) ? x_reg : left_reg;
    assign grow_right  = (we_reg && (x_end > right_reg)) ? x_end : right_reg;
    assign grow_top    = (we_reg && (y_reg < top_reg)) ? y_reg : top_reg;
    assign grow_bottom = (we_reg && (y_end > bottom_reg)) ? y_end : bottom_reg;

    always_comb
    begin
        if (scale_reg && pm_reg)
        begin
            color_sel = {scaled[3], scaled[2], scaled[1], scaled[0]};
        end
        else if (scale_reg)
        begin
            color_sel = {scaled[3], color_reg[3*CHAN_W-1:0]};
        end
        else
        begin
            color_sel = color_reg;
        end
    end

    always_comb
    begin
        tex_w_next = tex_w_reg;
        tex_h_next = tex_h_reg;
        color_next = color_reg;
        aa_next    = aa_reg;
        pm_next    = pm_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_TEX_W:   tex_w_next = cfg_data[COORD_W-1:0];
                REG_TEX_H:   tex_h_next = cfg_data[COORD_W-1:0];
                REG_COLOR:   color_next = cfg_data[COLOR_W-1:0];
                REG_AA:      aa_next    = cfg_data[0];
                REG_PREMULT: pm_next    = cfg_data[0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        cmd_next  = cmd_reg;
        ox_next   = ox_reg;
        oy_next   = oy_reg;
        col_next  = col_reg;
        row_next  = row_reg;
        cov_next  = cov_reg;
        full_next = full_reg;
        if (ctrl.load_in)
        begin
            cmd_next  = cmd;
            ox_next   = origin_x;
            oy_next   = origin_y;
            col_next  = glyph_col;
            row_next  = glyph_row;
            cov_next  = coverage;
            full_next = coverage_full;
        end
    end

    always_comb
    begin
        dirty_next      = dirty_reg;
        left_next       = left_reg;
        right_next      = right_reg;
        top_next        = top_reg;
        bottom_next     = bottom_reg;
        out_we_next     = out_we_reg;
        out_x_next      = out_x_reg;
        out_y_next      = out_y_reg;
        out_color_next  = out_color_reg;
        out_dirty_next  = out_dirty_reg;
        out_left_next   = out_left_reg;
        out_right_next  = out_right_reg;
        out_top_next    = out_top_reg;
        out_bottom_next = out_bottom_reg;
        if (ctrl.finish)
        begin
            out_we_next     = we_reg;
            out_x_next      = we_reg ? x_reg[POS_W-1:0] : '0;
            out_y_next      = we_reg ? y_reg[POS_W-1:0] : '0;
            out_color_next  = we_reg ? color_sel : '0;
            out_dirty_next  = grow_dirty;
            out_left_next   = grow_left;
            out_right_next  = grow_right;
            out_top_next    = grow_top;
            out_bottom_next = grow_bottom;
            if (flush_reg)
            begin
                dirty_next  = 1'b0;
                left_next   = eff_w;
                right_next  = '0;
                top_next    = eff_h;
                bottom_next = '0;
            end
            else
            begin
                dirty_next  = grow_dirty;
                left_next   = grow_left;
                right_next  = grow_right;
                top_next    = grow_top;
                bottom_next = grow_bottom;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tex_w_reg  <= RESET_DIM;
            tex_h_reg  <= RESET_DIM;
            color_reg  <= RESET_COLOR;
            aa_reg     <= 1'b1;
            pm_reg     <= 1'b0;
            dirty_reg  <= 1'b1;
            left_reg   <= '0;
            right_reg  <= RESET_DIM;
            top_reg    <= '0;
            bottom_reg <= RESET_DIM;
        end
        else
        begin
            tex_w_reg  <= tex_w_next;
            tex_h_reg  <= tex_h_next;
            color_reg  <= color_next;
            aa_reg     <= aa_next;
            pm_reg     <= pm_next;
            dirty_reg  <= dirty_next;
            left_reg   <= left_next;
            right_reg  <= right_next;
            top_reg    <= top_next;
            bottom_reg <= bottom_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        ox_reg         <= ox_next;
        oy_reg         <= oy_next;
        col_reg        <= col_next;
        row_reg        <= row_next;
        cov_reg        <= cov_next;
        full_reg       <= full_next;
        we_reg         <= we_next;
        x_reg          <= x_next;
        y_reg          <= y_next;
        scale_reg      <= scale_next;
        flush_reg      <= flush_next;
        out_we_reg     <= out_we_next;
        out_x_reg      <= out_x_next;
        out_y_reg      <= out_y_next;
        out_color_reg  <= out_color_next;
        out_dirty_reg  <= out_dirty_next;
        out_left_reg   <= out_left_next;
        out_right_reg  <= out_right_next;
        out_top_reg    <= out_top_next;
        out_bottom_reg <= out_bottom_next;
    end

    assign write_enable = out_we_reg;
    assign write_x      = out_x_reg;
    assign write_y      = out_y_reg;
    assign write_color  = out_color_reg;
    assign rect_dirty   = out_dirty_reg;
    assign rect_min_x   = out_left_reg;
    assign rect_max_x   = out_right_reg;
    assign rect_min_y   = out_top_reg;
    assign rect_max_y   = out_bottom_reg;

endmodule

>>> hdl/gcpw_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph coverage pixel writer controller
// Sequences capture, multiply, divider load, divide steps and output hand-off.
// ----------------------------------------------------------------------------
module gcpw_ctrl
    import gcpw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    output gcpw_ctrl_t ctrl
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_LOAD = 5'b00100,
        S_DIV  = 5'b01000,
        S_DONE = 5'b10000
    } gcpw_state_t;

    localparam int StepW = $clog2(CHAN_W);
    localparam logic [StepW-1:0] LastStep = StepW'(CHAN_W - 1);

    gcpw_state_t      state_reg, state_next;
    logic [StepW-1:0] step_reg, step_next;
    logic             valid_reg, valid_next;
    logic             out_free;

    assign out_free = !valid_reg || m_tready;
    assign s_tready = state_reg == S_IDLE;
    assign m_tvalid = valid_reg;

    always_comb
    begin
        state_next    = state_reg;
        step_next     = step_reg;
        valid_next    = valid_reg && !m_tready;
        ctrl          = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    ctrl.load_in = 1'b1;
                    state_next   = S_MUL;
                end
            end
            S_MUL:
            begin
                ctrl.mul   = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                ctrl.div_load = 1'b1;
                step_next     = '0;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                ctrl.div_step = 1'b1;
                step_next     = StepW'(step_reg + 1'b1);
                if (step_reg == LastStep)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    ctrl.finish = 1'b1;
                    valid_next  = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

endmodule

>>> hdl/gcpw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph coverage pixel writer checker
// Port-level properties of the writer, bound to the top level.
// ----------------------------------------------------------------------------
module gcpw_checker
    import gcpw_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [111:0]          m_tdata,
    input logic                  m_tuser
);

    // A stalled result stays offered.
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word dropped while stalled");

    // Only one word is in work at a time.
    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second word accepted during work");

    // Without a write, position and color read as zero.
    a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[55:0] == 56'd0)
        else $error("write fields not cleared without a write");

    // A pixel write always leaves the rectangle dirty.
    a_write_dirty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[56])
        else $error("pixel write without dirty rectangle");

endmodule

bind glyph_coverage_pixel_writer gcpw_checker u_gcpw_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
);

>>> test/glyph_coverage_pixel_writer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph coverage pixel writer testbench
// Streams glyph pixel, flush and direct write words into the block under
// several texture, color and mode settings, predicts each pixel write and
// dirty rectangle in the testbench, and compares every output word field by
// field. Both stream sides idle at random, and the receiver stalls once for
// a long stretch.
// ----------------------------------------------------------------------------
module glyph_coverage_pixel_writer_tb;
    import gcpw_pkg::*;

    localparam int MAX_DIM = 4096;
    localparam int CYCLE_LIMIT = 500000;
    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

    typedef struct {
        logic [CMD_W-1:0]          cmd;
        logic signed [COORD_W-1:0] ox;
        logic signed [COORD_W-1:0] oy;
        logic [GLYPH_W-1:0]        col;
        logic [GLYPH_W-1:0]        row;
        logic [CHAN_W-1:0]         cov;
        logic [CHAN_W-1:0]         full;
    } glyph_word_t;

    typedef struct {
        logic                  we;
        logic [POS_W-1:0]      wx;
        logic [POS_W-1:0]      wy;
        logic [COLOR_W-1:0]    color;
        logic                  dirty;
        logic [COORD_W-1:0]    min_x;
        logic [COORD_W-1:0]    max_x;
        logic [COORD_W-1:0]    min_y;
        logic [COORD_W-1:0]    max_y;
    } pixel_write_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [63:0]           s_tdata;
    logic [CMD_W-1:0]      s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [111:0]          m_tdata;
    logic                  m_tuser;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    glyph_word_t  glyph_q[$];
    pixel_write_t pixel_write_q[$];
    glyph_word_t  offered;

    logic [COORD_W-1:0] tex_w;
    logic [COORD_W-1:0] tex_h;
    logic [COLOR_W-1:0] ink_color;
    logic               aa_mode;
    logic               premult_mode;

    logic               rect_flag;
    logic [COORD_W-1:0] rect_left;
    logic [COORD_W-1:0] rect_right;
    logic [COORD_W-1:0] rect_top;
    logic [COORD_W-1:0] rect_bottom;

    int words_in;
    int errors;
    int cycles;
    int hold_left;
    logic hold_done;
    logic calm;

    glyph_coverage_pixel_writer #(.MAX_DIM(MAX_DIM)) uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int clamp_dim(logic [COORD_W-1:0] d);
        return (int'(d) > MAX_DIM) ? MAX_DIM : int'(d);
    endfunction

    function automatic logic [CHAN_W-1:0] scale_channel(int value, int cov, int full);
        int prod;
        int q;
        prod = value * cov;
        if (full == 0)
            return (prod != 0) ? CHAN_SAT : 8'd0;
        q = prod / full;
        return (q > 255) ? CHAN_SAT : q[7:0];
    endfunction

    function automatic pixel_write_t paint_pixel(glyph_word_t g);
        pixel_write_t r;
        int w;
        int h;
        int px;
        int pr;
        logic hit;
        logic [COLOR_W-1:0] c;
        w = clamp_dim(tex_w);
        h = clamp_dim(tex_h);
        r = '{default: '0};
        hit = 1'b0;
        c = '0;
        px = 0;
        pr = 0;
        if (g.cmd == CMD_GLYPH)
        begin
            px = int'(g.ox) + int'(g.col);
            pr = int'(g.oy) + int'(g.row);
            if (px >= 0 && px < w && pr >= 0 && pr < h)
            begin
                if (aa_mode)
                begin
                    if (g.cov != 0)
                    begin
                        hit = 1'b1;
                        c = ink_color;
                        c[31:24] = scale_channel(int'(ink_color[31:24]), int'(g.cov),
                                                 int'(g.full));
                        if (premult_mode)
                        begin
                            c[23:16] = scale_channel(int'(ink_color[23:16]), int'(g.cov),
                                                     int'(g.full));
                            c[15:8]  = scale_channel(int'(ink_color[15:8]), int'(g.cov),
                                                     int'(g.full));
                            c[7:0]   = scale_channel(int'(ink_color[7:0]), int'(g.cov),
                                                     int'(g.full));
                        end
                    end
                end
                else if ((g.cov & (8'h80 >> g.col[2:0])) != 0)
                begin
                    hit = 1'b1;
                    c = ink_color;
                end
                pr = h - 1 - pr;
            end
        end
        else if (g.cmd == CMD_DIRECT)
        begin
            px = int'(g.ox);
            pr = int'(g.oy);
            if (px >= 0 && px < w && pr >= 0 && pr < h)
            begin
                hit = 1'b1;
                c = ink_color;
            end
        end
        if (hit)
        begin
            r.we = 1'b1;
            r.wx = px[POS_W-1:0];
            r.wy = pr[POS_W-1:0];
            r.color = c;
            if (px < int'(rect_left))
                rect_left = px[COORD_W-1:0];
            if (px + 1 > int'(rect_right))
                rect_right = px[COORD_W-1:0] + 1'b1;
            if (pr < int'(rect_top))
                rect_top = pr[COORD_W-1:0];
            if (pr + 1 > int'(rect_bottom))
                rect_bottom = pr[COORD_W-1:0] + 1'b1;
            rect_flag = 1'b1;
        end
        r.dirty = rect_flag;
        r.min_x = rect_left;
        r.max_x = rect_right;
        r.min_y = rect_top;
        r.max_y = rect_bottom;
        if (g.cmd == CMD_FLUSH)
        begin
            rect_flag = 1'b0;
            rect_left = w[COORD_W-1:0];
            rect_right = '0;
            rect_top = h[COORD_W-1:0];
            rect_bottom = '0;
        end
        return r;
    endfunction

    function automatic glyph_word_t make_word(logic [CMD_W-1:0] cmd, int ox, int oy,
                                              int col, int row, int cov, int full);
        glyph_word_t g;
        g.cmd = cmd;
        g.ox = ox[COORD_W-1:0];
        g.oy = oy[COORD_W-1:0];
        g.col = col[7:0];
        g.row = row[7:0];
        g.cov = cov[7:0];
        g.full = full[7:0];
        return g;
    endfunction

    // Glyph pixels mostly land near the texture so that clipping edges and
    // the flip are exercised; a share uses fully random fields.
    function automatic glyph_word_t random_word();
        glyph_word_t g;
        int pick;
        int px;
        int pr;
        int col;
        int row;
        pick = $urandom_range(0, 99);
        g.cov = 8'($urandom_range(0, 255));
        g.full = ($urandom_range(0, 19) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
        if ($urandom_range(0, 3) == 0)
            g.cov = 8'($urandom_range(0, 3));
        if (pick < 80)
            g.cmd = CMD_GLYPH;
        else if (pick < 87)
            g.cmd = CMD_FLUSH;
        else if (pick < 97)
            g.cmd = CMD_DIRECT;
        else
            g.cmd = CMD_SPARE;
        if ($urandom_range(0, 4) == 0)
        begin
            g.ox = 13'($urandom);
            g.oy = 13'($urandom);
            g.col = 8'($urandom);
            g.row = 8'($urandom);
        end
        else
        begin
            px = int'($urandom_range(0, clamp_dim(tex_w) + 3)) - 2;
            pr = int'($urandom_range(0, clamp_dim(tex_h) + 3)) - 2;
            col = (g.cmd == CMD_GLYPH) ? int'($urandom_range(0, 255)) : 0;
            row = (g.cmd == CMD_GLYPH) ? int'($urandom_range(0, 255)) : 0;
            if (px - col > 4095)
                col = px - 4095;
            if (pr - row > 4095)
                row = pr - 4095;
            g.ox = 13'(px - col);
            g.oy = 13'(pr - row);
            g.col = (g.cmd == CMD_GLYPH) ? col[7:0] : 8'($urandom);
            g.row = (g.cmd == CMD_GLYPH) ? row[7:0] : 8'($urandom);
        end
        return g;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            REG_TEX_W:   tex_w = value[COORD_W-1:0];
            REG_TEX_H:   tex_h = value[COORD_W-1:0];
            REG_COLOR:   ink_color = value;
            REG_AA:      aa_mode = value[0];
            REG_PREMULT: premult_mode = value[0];
            default:     ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_mode(int w, int h, logic [31:0] color, logic aa, logic pm);
        write_reg(REG_TEX_W, w);
        write_reg(REG_TEX_H, h);
        write_reg(REG_COLOR, color);
        write_reg(REG_AA, {31'd0, aa});
        write_reg(REG_PREMULT, {31'd0, pm});
    endtask

    task automatic drain();
        wait (glyph_q.size() == 0 && !s_tvalid && pixel_write_q.size() == 0);
        repeat (16) @(posedge clk);
    endtask

    task automatic run_random(int count);
        @(negedge clk);
        repeat (count) glyph_q.push_back(random_word());
        drain();
    endtask

    // Sender: holds the offered word until it is taken, and idles at random
    // only between words.
    always @(posedge clk or negedge rst_n)
    begin : sender
        logic fire;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= '0;
        end
        else
        begin
            fire = s_tvalid && s_tready;
            if (fire)
            begin
                pixel_write_q.push_back(paint_pixel(offered));
                words_in <= words_in + 1;
            end
            if (s_tvalid && !fire)
                ;
            else if (glyph_q.size() > 0 && (calm || $urandom_range(0, 99) >= 30))
            begin
                offered = glyph_q.pop_front();
                s_tvalid <= 1'b1;
                s_tuser <= offered.cmd;
                s_tdata <= {6'd0, offered.full, offered.cov, offered.row, offered.col,
                            offered.oy, offered.ox};
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    assign calm = (words_in >= 700 && words_in < 900);

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end
        else if (!hold_done && words_in >= 300)
        begin
            hold_left <= 200;
            hold_done <= 1'b1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= calm || ($urandom_range(0, 99) >= 30);
    end

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s expected %0h actual %0h", name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin : monitor
        pixel_write_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pixel_write_q.size() == 0)
            begin
                $error("output word with no expected word pending");
                errors++;
            end
            else
            begin
                e = pixel_write_q.pop_front();
                check_field("write_enable", 32'(e.we), 32'(m_tuser));
                check_field("write_x", 32'(e.wx), 32'(m_tdata[11:0]));
                check_field("write_y", 32'(e.wy), 32'(m_tdata[23:12]));
                check_field("write_color", e.color, m_tdata[55:24]);
                check_field("rect_dirty", 32'(e.dirty), 32'(m_tdata[56]));
                check_field("rect_min_x", 32'(e.min_x), 32'(m_tdata[69:57]));
                check_field("rect_max_x", 32'(e.max_x), 32'(m_tdata[82:70]));
                check_field("rect_min_y", 32'(e.min_y), 32'(m_tdata[95:83]));
                check_field("rect_max_y", 32'(e.max_y), 32'(m_tdata[108:96]));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("glyph_coverage_pixel_writer: mismatch");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        words_in = 0;
        errors = 0;
        cycles = 0;
        tex_w = RESET_DIM;
        tex_h = RESET_DIM;
        ink_color = RESET_COLOR;
        aa_mode = 1'b1;
        premult_mode = 1'b0;
        rect_flag = 1'b1;
        rect_left = '0;
        rect_right = RESET_DIM;
        rect_top = '0;
        rect_bottom = RESET_DIM;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        @(negedge clk);
        glyph_q.push_back(make_word(CMD_FLUSH, 0, 0, 0, 0, 0, 1));
        glyph_q.push_back(make_word(CMD_GLYPH, 0, 0, 0, 0, 255, 255));
        glyph_q.push_back(make_word(CMD_GLYPH, 200, 200, 55, 55, 128, 255));
        glyph_q.push_back(make_word(CMD_GLYPH, 1, 3, 255, 0, 255, 255));
        glyph_q.push_back(make_word(CMD_GLYPH, 5, -4096, 0, 0, 255, 255));
        glyph_q.push_back(make_word(CMD_GLYPH, 4095, 4095, 255, 255, 255, 255));
        glyph_q.push_back(make_word(CMD_GLYPH, 10, 10, 2, 2, 0, 255));
        glyph_q.push_back(make_word(CMD_GLYPH, 10, 10, 3, 4, 200, 100));
        glyph_q.push_back(make_word(CMD_GLYPH, 20, 30, 1, 1, 5, 0));
        glyph_q.push_back(make_word(CMD_DIRECT, 0, 0, 0, 0, 0, 0));
        glyph_q.push_back(make_word(CMD_DIRECT, 255, 255, 255, 255, 255, 255));
        glyph_q.push_back(make_word(CMD_DIRECT, -1, 0, 0, 0, 0, 0));
        glyph_q.push_back(make_word(CMD_DIRECT, 256, 3, 0, 0, 0, 0));
        glyph_q.push_back(make_word(CMD_SPARE, 7, 7, 7, 7, 7, 7));
        glyph_q.push_back(make_word(CMD_FLUSH, 0, 0, 0, 0, 0, 1));
        glyph_q.push_back(make_word(CMD_FLUSH, -4096, -4096, 255, 255, 255, 255));
        glyph_q.push_back(make_word(CMD_GLYPH, -255, -255, 255, 255, 1, 1));
        drain();

        set_mode(256, 256, 32'h8040_2010, 1'b1, 1'b1);
        @(negedge clk);
        glyph_q.push_back(make_word(CMD_GLYPH, 40, 50, 0, 0, 128, 255));
        glyph_q.push_back(make_word(CMD_GLYPH, 40, 50, 1, 0, 255, 3));
        glyph_q.push_back(make_word(CMD_GLYPH, 40, 50, 2, 0, 9, 0));
        drain();

        set_mode(256, 256, 32'h1234_5678, 1'b0, 1'b0);
        @(negedge clk);
        glyph_q.push_back(make_word(CMD_GLYPH, 16, 16, 0, 0, 8'h80, 1));
        glyph_q.push_back(make_word(CMD_GLYPH, 16, 16, 7, 0, 8'h01, 1));
        glyph_q.push_back(make_word(CMD_GLYPH, 16, 16, 9, 0, 8'hBF, 1));
        glyph_q.push_back(make_word(CMD_GLYPH, 16, 16, 12, 0, 8'h00, 1));
        glyph_q.push_back(make_word(CMD_FLUSH, 0, 0, 0, 0, 0, 1));
        drain();

        set_mode(64, 48, $urandom, 1'b1, 1'b0);
        run_random(195);
        set_mode(1, 1, $urandom, 1'b1, 1'b1);
        run_random(195);
        set_mode(4096, 4096, 32'hFFFF_FFFF, 1'b1, 1'b1);
        run_random(195);
        set_mode(8191, 5000, 32'h0000_0000, 1'b0, 1'b0);
        run_random(195);
        set_mode(0, 17, $urandom, 1'b1, 1'b0);
        run_random(195);
        set_mode(13, 200, $urandom, 1'b0, 1'b1);
        run_random(195);
        set_mode($urandom_range(1, 300), $urandom_range(1, 300), $urandom,
                 1'($urandom), 1'($urandom));
        run_random(195);

        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("glyph_coverage_pixel_writer: match");
        else
            $display("glyph_coverage_pixel_writer: mismatch");
        $finish;
    end

endmodule
